@@ rtl/indexed_min_heap_queue_defines.svh @@
// Assertion macros shared by the indexed min-heap queue RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside of reset.
`define IMHQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside of reset.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/imhq_pkg.sv @@
// Package with types, codes and defaults of the indexed min-heap queue.
package imhq_pkg;

  // Defaults of the top-level parameters.
  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths and handle space.
  localparam int HANDLE_W     = 10;
  localparam int KEY_W        = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 3;
  localparam int HANDLE_SPACE = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_UPDATE     = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ROOT,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FIN,
    S_DONE
  } state_e;

  // Result of one transaction, passed from the sequencer to the output stage.
  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } res_t;

endpackage

@@ rtl/imhq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/imhq_ctrl.sv @@
// Sequencer of the heap: handle lookup, sift up and sift down over two RAMs.
module imhq_ctrl
  import imhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o,
  output logic [CW-1:0]       count_o
);

`include "indexed_min_heap_queue_defines.svh"

  localparam int PW = $clog2(CAPACITY);
  localparam int XW = PW + 2;
  localparam int EW = HANDLE_W + KEY_BITS;
  localparam int MW = PW + 1;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       count_q, count_d;
  logic [HANDLE_W-1:0] mv_h_q, mv_h_d;
  logic [KEY_BITS-1:0] mv_k_q, mv_k_d;
  logic [EW-1:0]       lft_q, lft_d;
  logic                up_q, up_d;
  status_e             status_q, status_d;
  logic [HANDLE_W-1:0] oh_q, oh_d;
  logic [KEY_W-1:0]    ok_q, ok_d;
  logic [HANDLE_W-1:0] clr_q, clr_d;

  // Memory ports.
  logic                hw_en;
  logic [PW-1:0]       hw_addr;
  logic [EW-1:0]       hw_data;
  logic [PW-1:0]       hr_addr;
  logic [EW-1:0]       hr_data;
  logic                pw_en;
  logic [HANDLE_W-1:0] pw_addr;
  logic [MW-1:0]       pw_data;
  logic [HANDLE_W-1:0] pr_addr;
  logic [MW-1:0]       pr_data;

  // Decoded read data and position arithmetic.
  logic [HANDLE_W-1:0] rd_h;
  logic [KEY_BITS-1:0] rd_k;
  logic [KEY_BITS-1:0] lft_k;
  logic                pm_present;
  logic [PW-1:0]       pm_pos;
  logic [PW-1:0]       parent;
  logic [PW-1:0]       last;
  logic [XW-1:0]       l_x, r_x, cnt_x;
  logic                l_ok, r_ok;
  logic                take_r;
  logic [EW-1:0]       c_ent;
  logic [PW-1:0]       c_pos;

  // Heap array: handle and key per position.
  imhq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (hw_en),
    .waddr_i(hw_addr),
    .wdata_i(hw_data),
    .raddr_i(hr_addr),
    .rdata_o(hr_data)
  );

  // Handle map: present flag and heap position per handle.
  imhq_ram #(
    .WIDTH(MW),
    .DEPTH(HANDLE_SPACE)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (pw_en),
    .waddr_i(pw_addr),
    .wdata_i(pw_data),
    .raddr_i(pr_addr),
    .rdata_o(pr_data)
  );

  assign rd_h       = hr_data[EW-1 -: HANDLE_W];
  assign rd_k       = hr_data[KEY_BITS-1:0];
  assign lft_k      = lft_q[KEY_BITS-1:0];
  assign pm_present = pr_data[PW];
  assign pm_pos     = pr_data[PW-1:0];
  assign parent     = (pos_q - 1'b1) >> 1;
  assign last       = PW'(count_q - 1'b1);
  assign l_x        = {1'b0, pos_q, 1'b1};
  assign r_x        = l_x + 1'b1;
  assign cnt_x      = XW'(count_q);
  assign l_ok       = l_x < cnt_x;
  assign r_ok       = r_x < cnt_x;
  assign take_r     = r_ok && (rd_k < lft_k);
  assign c_ent      = take_r ? hr_data : lft_q;
  assign c_pos      = take_r ? PW'(r_x) : PW'(l_x);

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      count_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    handle_q <= handle_d;
    key_q    <= key_d;
    pos_q    <= pos_d;
    mv_h_q   <= mv_h_d;
    mv_k_q   <= mv_k_d;
    lft_q    <= lft_d;
    up_q     <= up_d;
    status_q <= status_d;
    oh_q     <= oh_d;
    ok_q     <= ok_d;
  end

  // Next state, memory requests and handshakes.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    handle_d = handle_q;
    key_d    = key_q;
    pos_d    = pos_q;
    count_d  = count_q;
    mv_h_d   = mv_h_q;
    mv_k_d   = mv_k_q;
    lft_d    = lft_q;
    up_d     = up_q;
    status_d = status_q;
    oh_d     = oh_q;
    ok_d     = ok_q;
    clr_d    = clr_q;
    hw_en    = 1'b0;
    hw_addr  = pos_q;
    hw_data  = {mv_h_q, mv_k_q};
    hr_addr  = '0;
    pw_en    = 1'b0;
    pw_addr  = mv_h_q;
    pw_data  = {1'b1, pos_q};
    pr_addr  = handle_i;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // Sweep the handle map so that every handle starts absent.
        pw_en   = 1'b1;
        pw_addr = clr_q;
        pw_data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // Take a transaction and start the map or root read at once.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = op_e'(op_i);
          handle_d = handle_i;
          key_d    = KEY_BITS'(key_i);
          up_d     = 1'b0;
          status_d = ST_OK;
          oh_d     = '0;
          ok_d     = '0;
          if (op_e'(op_i) == OP_REMOVE_MIN) begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              state_d = S_ROOT;
            end
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // Map entry of the handle is available; resolve errors.
        mv_h_d = handle_q;
        mv_k_d = key_q;
        case (op_q)
          OP_INSERT: begin
            if (pm_present) begin
              status_d = ST_PRESENT;
              state_d  = S_DONE;
            end else if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              pos_d   = PW'(count_q);
              count_d = count_q + 1'b1;
              state_d = S_UP_RD;
            end
          end
          OP_UPDATE: begin
            if (!pm_present) begin
              status_d = ST_ABSENT;
              state_d  = S_DONE;
            end else begin
              pos_d   = pm_pos;
              state_d = S_UP_RD;
            end
          end
          OP_REMOVE: begin
            if (!pm_present) begin
              status_d = ST_ABSENT;
              state_d  = S_DONE;
            end else begin
              pw_en   = 1'b1;
              pw_addr = handle_q;
              pw_data = '0;
              count_d = count_q - 1'b1;
              pos_d   = pm_pos;
              if (pm_pos < last) begin
                hr_addr = last;
                state_d = S_LAST;
              end else begin
                state_d = S_DONE;
              end
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_ROOT: begin
        // Root is read: it is the result; the last element refills the root.
        oh_d    = rd_h;
        ok_d    = KEY_W'(rd_k);
        pw_en   = 1'b1;
        pw_addr = rd_h;
        pw_data = '0;
        count_d = count_q - 1'b1;
        pos_d   = '0;
        if (count_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          hr_addr = last;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        mv_h_d  = rd_h;
        mv_k_d  = rd_k;
        state_d = S_UP_RD;
      end
      S_UP_RD: begin
        // Fetch the parent, or switch to sifting down at the root.
        if (pos_q == '0) begin
          state_d = up_q ? S_FIN : S_DN_RDL;
        end else begin
          hr_addr = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // A larger parent moves down into the hole.
        if (rd_k > mv_k_q) begin
          hw_en   = 1'b1;
          hw_data = hr_data;
          pw_en   = 1'b1;
          pw_addr = rd_h;
          pos_d   = parent;
          up_d    = 1'b1;
          state_d = S_UP_RD;
        end else begin
          state_d = up_q ? S_FIN : S_DN_RDL;
        end
      end
      S_DN_RDL: begin
        if (!l_ok) begin
          state_d = S_FIN;
        end else begin
          hr_addr = PW'(l_x);
          state_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lft_d = hr_data;
        if (r_ok) begin
          hr_addr = PW'(r_x);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        // The smaller child, left on a tie, moves up into the hole.
        if (mv_k_q > c_ent[KEY_BITS-1:0]) begin
          hw_en   = 1'b1;
          hw_data = c_ent;
          pw_en   = 1'b1;
          pw_addr = c_ent[EW-1 -: HANDLE_W];
          pos_d   = c_pos;
          state_d = S_DN_RDL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Settle the moving element in the hole.
        hw_en   = 1'b1;
        pw_en   = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o   = '{status: status_q, handle: oh_q, key: ok_q};
  assign count_o = count_q;

  `IMHQ_ASSERT_SAME(a_count_cap, 1'b1, count_q <= CW'(CAPACITY),
                    "item count above capacity")
  `IMHQ_ASSERT_SAME(a_heap_wr_range, hw_en, XW'(hw_addr) < cnt_x,
                    "heap write beyond the item count")
  `IMHQ_ASSERT_SAME(a_no_take_clear, state_q == S_CLEAR, !in_ready_o,
                    "transaction taken during the map clear")
  `IMHQ_ASSERT_NEXT(a_empty_status,
                    in_ready_o && in_valid_i && op_i == OP_REMOVE_MIN && count_q == '0,
                    status_q == ST_EMPTY && state_q == S_DONE,
                    "remove minimum on an empty heap not flagged")

endmodule

@@ rtl/indexed_min_heap_queue.sv @@
// Indexed binary min-heap priority queue: top level with the result register.
//
// Usage: a transaction on the input channel (in_valid_i/in_ready_o) carries an
// operation, a handle and a key: insert, remove minimum, remove by handle or
// change the key of a handle. Each transaction gives exactly one result on the
// output channel (out_valid_o/out_ready_i): a status, the handle and key taken
// out by a remove minimum (zero otherwise), and the item count afterwards.
// Items are handled one at a time. Error cases and removals that need no
// repair finish without a sift. Each level of a sift up passes through the
// states S_UP_RD and S_UP_CMP, and each level down through S_DN_RDL, S_DN_RDR
// and S_DN_CMP, since the single read port of the heap RAM reads the two
// children one after the other. The result shows on out_valid_o in the
// cycle in which the next transaction can be accepted.
// After reset the handle map is cleared one entry a cycle, during which
// in_ready_o stays low; the heap starts empty.
// A result waits in the output register while the receiver stalls; the next
// transaction may be accepted and worked on meanwhile, and it finishes once
// that register has been taken.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [KEY_W-1:0]    out_key_o,
  output logic [CW-1:0]       count_o
);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [CW-1:0] res_count;

  logic          out_valid_q;
  res_t          out_q;
  logic [CW-1:0] count_q;

  imhq_ctrl #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .handle_i   (handle_i),
    .key_i      (key_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .count_o    (res_count)
  );

  // The result register is free when empty or being taken this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q   <= res;
      count_q <= res_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign out_handle_o = out_q.handle;
  assign out_key_o    = out_q.key;
  assign count_o      = count_q;

endmodule
